### rtl/crpe_pkg.sv
// shared types, constants and count-varint helpers for the column run prefix encoder
`timescale 1ns / 1ps

package crpe_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int LEN_W       = 6;
	localparam int CNT_W       = 32;

	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_EMPTY = 2'd1;
	localparam logic [1:0] MODE_NULL  = 2'd2;
	localparam logic [1:0] MODE_FLUSH = 2'd3;

	localparam logic [7:0] NULL_MARK = 8'hff;
	localparam logic [7:0] CONT_BIT  = 8'h80;

	// one closed run, handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [7:0]       level;
		logic             is_null;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] pfx;
		logic             ovf;
		logic             bank;
	} rec_cmd_t;

	// number of bytes in the count varint
	function automatic logic [2:0] count_nbytes(input logic [CNT_W-1:0] v);
		logic [2:0] n;
		begin
			if (v < 32'd128)           n = 3'd1;
			else if (v < 32'd8192)     n = 3'd2;
			else if (v < 32'd1048576)  n = 3'd3;
			else if (v < 32'd134217728) n = 3'd4;
			else                       n = 3'd5;
			return n;
		end
	endfunction

	// byte j of the count varint that has n bytes
	function automatic logic [7:0] count_byte(input logic [CNT_W-1:0] v,
		input logic [2:0] j, input logic [2:0] n);
		logic [CNT_W-1:0] s;
		logic [7:0]       b;
		begin
			case (j)
				3'd1:    s = v >> 6;
				3'd2:    s = v >> 13;
				3'd3:    s = v >> 20;
				default: s = v >> 27;
			endcase
			if (j == 3'd0)
				b = (n == 3'd1) ? v[7:0] : {2'b10, v[5:0]};
			else
				b = s[7:0] | ((j != n - 3'd1) ? CONT_BIT : 8'h00);
			return b;
		end
	endfunction

endpackage

### rtl/column_run_prefix_encoder.sv
// top level of the column run prefix encoder
`timescale 1ns / 1ps

// Run-length, front-coding encoder for one column. Each input word is a value
// byte, an empty value, a null or a flush; repeats merge into runs and every
// closed run leaves as one record, one byte per output word. An input word
// occupies the front in an accept state and then an update state, which waits for
// the registered lookup of the previous value byte. Records stream out at one byte
// per cycle while the output is not stalled for the count, level and length bytes;
// each value byte first waits in a fetch state for the registered read port of the
// value memory. A two-entry run queue lets the front go on while a record
// drains; any input word is held off while a record still needs the memory bank
// that new value bytes would overwrite, or while the run queue is full and the
// word closes a run. No clearing pass after reset.
module column_run_prefix_encoder import crpe_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] data_byte,
	input  logic [7:0] level,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       record_end,
	output logic       overlong
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	logic        mem_we;
	logic [AW:0] mem_waddr, mem_raddr;
	logic [7:0]  mem_wdata, mem_rdata;
	logic        f_valid, f_ready, b_valid, b_ready;
	rec_cmd_t    f_cmd, b_cmd;
	logic [1:0]  q_busy, b_busy, busy;

	assign busy = q_busy | b_busy;

	crpe_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.data_byte (data_byte),
		.level     (level),
		.last_byte (last_byte),
		.bank_busy (busy),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	crpe_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd),
		.bank_busy  (q_busy)
	);

	crpe_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (b_valid),
		.cmd_ready  (b_ready),
		.cmd        (b_cmd),
		.bank_busy  (b_busy),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.record_end (record_end),
		.overlong   (overlong)
	);

endmodule

### rtl/crpe_front.sv
// front: accepts items, builds the incoming value, tracks the run and closes runs
`timescale 1ns / 1ps

module crpe_front import crpe_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF,
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [7:0]       data_byte,
	input  logic [7:0]       level,
	input  logic             last_byte,
	input  logic [1:0]       bank_busy,
	output logic             mem_we,
	output logic [AW:0]      mem_waddr,
	output logic [7:0]       mem_wdata,
	output logic [AW:0]      mem_raddr,
	input  logic [7:0]       mem_rdata,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output rec_cmd_t         cmd
);

	localparam logic F_IDLE = 1'b0;
	localparam logic F_EXEC = 1'b1;
	localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_LEN);

	logic             state_q;
	logic [1:0]       mode_s1;
	logic [7:0]       byte_s1;
	logic [7:0]       lvl_s1;
	logic             last_s1;

	logic             run_bank_q;
	logic [LEN_W-1:0] inc_len_q, inc_pfx_q, run_len_q, run_pfx_q;
	logic             pse_q, inc_trunc_q;
	logic [CNT_W-1:0] run_cnt_q;
	logic [7:0]       run_lvl_q;
	logic             run_null_q, ovf_q;

	logic             fits, match, ends, equal, close_ev, push, go, cnt_max;
	logic [LEN_W-1:0] n_len, n_pfx;
	logic             n_trunc, n_pse;

	logic             acc;

	assign in_ready  = (state_q == F_IDLE) && !bank_busy[~run_bank_q];
	assign acc       = in_valid && in_ready;
	assign mem_raddr = {run_bank_q, inc_len_q[AW-1:0]};
	assign mem_waddr = {~run_bank_q, inc_len_q[AW-1:0]};
	assign mem_wdata = byte_s1;
	assign cnt_max   = &run_cnt_q;

	always_comb begin
		fits  = inc_len_q < MAXL;
		match = pse_q && (inc_len_q < run_len_q) && (mem_rdata == byte_s1);
		if (mode_s1 == MODE_BYTE) begin
			n_len   = fits ? inc_len_q + LEN_W'(1) : inc_len_q;
			n_pfx   = (fits && match) ? inc_pfx_q + LEN_W'(1) : inc_pfx_q;
			n_pse   = fits ? match : pse_q;
			n_trunc = inc_trunc_q | !fits;
			ends    = last_s1;
		end else begin
			n_len   = '0;
			n_pfx   = '0;
			n_pse   = 1'b1;
			n_trunc = 1'b0;
			ends    = (mode_s1 == MODE_EMPTY);
		end
		equal = !run_null_q && (n_pfx == n_len) && (n_len == run_len_q);
		case (mode_s1)
			MODE_NULL:  close_ev = (lvl_s1 != run_lvl_q) || !run_null_q || cnt_max;
			MODE_FLUSH: close_ev = 1'b1;
			default:    close_ev = ends &&
				((lvl_s1 != run_lvl_q) || !equal || cnt_max);
		endcase
		push = close_ev && (run_cnt_q != '0);
		go   = !push || cmd_ready;
	end

	assign cmd_valid = (state_q == F_EXEC) && push;
	assign mem_we    = (state_q == F_EXEC) && go && (mode_s1 == MODE_BYTE) && fits;

	always_comb begin
		cmd.count   = run_cnt_q;
		cmd.level   = run_lvl_q;
		cmd.is_null = run_null_q;
		cmd.len     = run_len_q;
		cmd.pfx     = run_pfx_q;
		cmd.ovf     = ovf_q;
		cmd.bank    = run_bank_q;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
			lvl_s1  <= level;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			run_bank_q  <= 1'b0;
			inc_len_q   <= '0;
			inc_pfx_q   <= '0;
			pse_q       <= 1'b1;
			inc_trunc_q <= 1'b0;
			run_len_q   <= '0;
			run_pfx_q   <= '0;
			run_cnt_q   <= '0;
			run_lvl_q   <= '0;
			run_null_q  <= 1'b1;
			ovf_q       <= 1'b0;
		end else if (state_q == F_IDLE) begin
			if (acc)
				state_q <= F_EXEC;
		end else if (go) begin
			state_q <= F_IDLE;
			if (mode_s1 == MODE_FLUSH) begin
				run_cnt_q  <= '0;
				run_null_q <= 1'b1;
				ovf_q      <= 1'b0;
			end else if (mode_s1 == MODE_NULL) begin
				run_lvl_q  <= lvl_s1;
				run_null_q <= 1'b1;
				run_cnt_q  <= close_ev ? CNT_W'(1) : run_cnt_q + CNT_W'(1);
				if (push)
					ovf_q <= 1'b0;
			end else if (ends) begin
				if (close_ev) begin
					if (!equal) begin
						// new value sits in the other bank
						run_bank_q <= ~run_bank_q;
						run_len_q  <= n_len;
						run_pfx_q  <= run_null_q ? '0 : n_pfx;
					end else begin
						run_pfx_q  <= run_len_q;
					end
					run_null_q <= 1'b0;
				end
				run_lvl_q <= lvl_s1;
				run_cnt_q <= close_ev ? CNT_W'(1) : run_cnt_q + CNT_W'(1);
				ovf_q     <= (push ? 1'b0 : ovf_q) | n_trunc;
			end
			if (ends || mode_s1 != MODE_BYTE) begin
				inc_len_q   <= '0;
				inc_pfx_q   <= '0;
				pse_q       <= 1'b1;
				inc_trunc_q <= 1'b0;
			end else begin
				inc_len_q   <= n_len;
				inc_pfx_q   <= n_pfx;
				pse_q       <= n_pse;
				inc_trunc_q <= n_trunc;
			end
		end
	end

endmodule

### rtl/crpe_cmd_fifo.sv
// two-entry queue of closed runs between front and back
`timescale 1ns / 1ps

module crpe_cmd_fifo import crpe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  rec_cmd_t push_cmd,
	output logic     pop_valid,
	input  logic     pop_ready,
	output rec_cmd_t pop_cmd,
	output logic [1:0] bank_busy
);

	rec_cmd_t   ent_q [2];
	logic [1:0] vld_q;
	logic       wr_ptr_q, rd_ptr_q;

	assign push_ready = !vld_q[wr_ptr_q];
	assign pop_valid  = vld_q[rd_ptr_q];
	assign pop_cmd    = ent_q[rd_ptr_q];

	// value records still to be replayed pin their bank
	always_comb begin
		bank_busy = 2'b00;
		for (int e = 0; e < 2; e++)
			if (vld_q[e] && !ent_q[e].is_null)
				bank_busy[ent_q[e].bank] = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready)
			ent_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= 2'b00;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push_valid && push_ready) begin
				vld_q[wr_ptr_q] <= 1'b1;
				wr_ptr_q        <= ~wr_ptr_q;
			end
			if (pop_valid && pop_ready) begin
				vld_q[rd_ptr_q] <= 1'b0;
				rd_ptr_q        <= ~rd_ptr_q;
			end
		end
	end

endmodule

### rtl/crpe_back.sv
// back: value memory and record sequencer with output register
`timescale 1ns / 1ps

module crpe_back import crpe_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF,
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  rec_cmd_t    cmd,
	output logic [1:0]  bank_busy,
	input  logic        mem_we,
	input  logic [AW:0] mem_waddr,
	input  logic [7:0]  mem_wdata,
	input  logic [AW:0] mem_raddr,
	output logic [7:0]  mem_rdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        record_end,
	output logic        overlong
);

	localparam int DEPTH = 2 ** (AW + 1);

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_CNT   = 3'd1;
	localparam logic [2:0] B_LVL   = 3'd2;
	localparam logic [2:0] B_VAL   = 3'd3;
	localparam logic [2:0] B_LEN   = 3'd4;
	localparam logic [2:0] B_FETCH = 3'd5;
	localparam logic [2:0] B_DATA  = 3'd6;

	logic [7:0]       mem_q [DEPTH];
	logic [7:0]       rd_b_q;
	logic [2:0]       st_q, nxt;
	logic [2:0]       j_q;
	logic [LEN_W-1:0] idx_q;
	rec_cmd_t         act_q;

	logic             slot, emit, e_last, use_p;
	logic [7:0]       e_byte;
	logic [2:0]       nb;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		mem_rdata <= mem_q[mem_raddr];
		rd_b_q    <= mem_q[{act_q.bank, idx_q[AW-1:0]}];
	end

	assign cmd_ready = (st_q == B_IDLE);
	assign slot      = !out_valid || out_ready;
	assign nb        = count_nbytes(act_q.count);
	assign use_p     = act_q.pfx > LEN_W'(2);

	always_comb begin
		bank_busy = 2'b00;
		if (st_q != B_IDLE && !act_q.is_null)
			bank_busy[act_q.bank] = 1'b1;
	end

	always_comb begin
		emit   = 1'b0;
		e_byte = 8'h00;
		e_last = 1'b0;
		nxt    = st_q;
		case (st_q)
			B_IDLE: begin
				if (cmd_valid)
					nxt = B_CNT;
			end
			B_CNT: begin
				emit   = 1'b1;
				e_byte = count_byte(act_q.count, j_q, nb);
				if (j_q == nb - 3'd1)
					nxt = B_LVL;
			end
			B_LVL: begin
				emit   = 1'b1;
				e_byte = act_q.level;
				nxt    = B_VAL;
			end
			B_VAL: begin
				emit = 1'b1;
				if (act_q.is_null) begin
					e_byte = NULL_MARK;
					e_last = 1'b1;
					nxt    = B_IDLE;
				end else if (use_p) begin
					e_byte = {2'b11, act_q.pfx - LEN_W'(2)};
					nxt    = B_LEN;
				end else begin
					e_byte = {2'b00, act_q.len};
					e_last = (act_q.len == '0);
					nxt    = e_last ? B_IDLE : B_FETCH;
				end
			end
			B_LEN: begin
				emit   = 1'b1;
				e_byte = {2'b00, act_q.len - act_q.pfx};
				e_last = (act_q.len == act_q.pfx);
				nxt    = e_last ? B_IDLE : B_FETCH;
			end
			B_FETCH: begin
				nxt = B_DATA;
			end
			B_DATA: begin
				emit   = 1'b1;
				e_byte = rd_b_q;
				e_last = (idx_q == act_q.len - LEN_W'(1));
				nxt    = e_last ? B_IDLE : B_FETCH;
			end
			default: begin
				nxt = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && cmd_valid)
			act_q <= cmd;
		if (emit && slot) begin
			out_byte   <= e_byte;
			record_end <= e_last;
			overlong   <= act_q.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			j_q       <= '0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (st_q == B_IDLE) begin
				st_q <= nxt;
				j_q  <= '0;
			end else if (st_q == B_FETCH) begin
				st_q <= nxt;
			end else if (emit && slot) begin
				st_q <= nxt;
				if (st_q == B_CNT)
					j_q <= j_q + 3'd1;
				if (st_q == B_VAL)
					idx_q <= '0;
				else if (st_q == B_LEN)
					idx_q <= act_q.pfx;
				else if (st_q == B_DATA)
					idx_q <= idx_q + LEN_W'(1);
			end
			if (emit && slot)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

endmodule

### tb/tb_top.sv
// self-checking testbench for the column run prefix encoder
`timescale 1ns / 1ps

module tb_top;
	import crpe_pkg::*;

	localparam int VAL_CAP = 32;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] data;
		logic [7:0] lvl;
		logic       last;
	} word_t;

	typedef struct {
		logic [7:0] b;
		logic       rend;
		logic       ovl;
	} rec_byte_t;

	// directed row: one word plus, where obvious, the record bytes it must produce
	typedef struct {
		word_t      w;
		int         n_typed;
		logic [7:0] typed [6];
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] mode;
	logic [7:0] data_byte;
	logic [7:0] level;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       record_end;
	logic       overlong;

	column_run_prefix_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .data_byte(data_byte), .level(level), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .record_end(record_end), .overlong(overlong)
	);

	// encoder shadow state
	logic [7:0]  run_val [64];
	logic [7:0]  inc_val [64];
	int unsigned run_len, inc_len, inc_pfx, run_pfx, run_lvl;
	logic [31:0] run_cnt;
	bit          pfx_eq, run_null, ovf_seen, inc_trunc;

	rec_byte_t   record_q [$];
	int          idle_pct;
	int          stall_pct;
	int          n_pred;
	int          n_sent;
	bit          failed;
	bit          sb_failed;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void put_byte(input logic [31:0] v);
		rec_byte_t r;
		r.b = v[7:0];
		r.rend = 1'b0;
		r.ovl = ovf_seen;
		record_q.insert(record_q.size(), r);
		n_pred++;
	endfunction

	function automatic void put_varint(input logic [31:0] v);
		if (v < 32'd128) begin
			put_byte(v);
		end else begin
			put_byte((v & 32'h3f) | 32'h80);
			if (v < 32'd8192) begin
				put_byte(v >> 6);
			end else if (v < 32'd1048576) begin
				put_byte(((v >> 6) & 32'hff) | 32'h80);
				put_byte(v >> 13);
			end else if (v < 32'd134217728) begin
				put_byte(((v >> 6) & 32'hff) | 32'h80);
				put_byte(((v >> 13) & 32'hff) | 32'h80);
				put_byte(v >> 20);
			end else begin
				put_byte(((v >> 6) & 32'hff) | 32'h80);
				put_byte(((v >> 13) & 32'hff) | 32'h80);
				put_byte(((v >> 20) & 32'hff) | 32'h80);
				put_byte(v >> 27);
			end
		end
	endfunction

	function automatic void close_run();
		int unsigned len;
		int unsigned p;
		if (run_cnt == 0)
			return;
		put_varint(run_cnt);
		put_byte(run_lvl);
		if (run_null) begin
			put_byte(32'(NULL_MARK));
		end else begin
			len = (run_len > VAL_CAP) ? VAL_CAP : run_len;
			p = (run_pfx > len) ? len : run_pfx;
			if (p > 2) begin
				if (p > 64)
					p = 64;
				put_byte(32'hc0 | (p - 2));
				put_varint(len - p);
				for (int unsigned i = p; i < len; i++)
					put_byte(32'(run_val[i]));
			end else begin
				put_varint(len);
				for (int unsigned i = 0; i < len; i++)
					put_byte(32'(run_val[i]));
			end
		end
		record_q[$].rend = 1'b1;
		run_cnt = 0;
		run_null = 1'b1;
		ovf_seen = 1'b0;
	endfunction

	function automatic void clear_incoming();
		inc_len = 0;
		inc_pfx = 0;
		pfx_eq = 1'b1;
		inc_trunc = 1'b0;
	endfunction

	function automatic void end_value(input logic [7:0] lv);
		bit          same;
		int unsigned shared;
		same = !run_null && inc_pfx == inc_len && inc_len == run_len;
		shared = run_null ? 0 : inc_pfx;
		if (lv != run_lvl || !same || run_cnt == 32'hffffffff) begin
			close_run();
			if (!same) begin
				run_val = inc_val;
				run_len = inc_len;
				run_pfx = shared;
			end else begin
				run_pfx = run_len;
			end
			run_null = 1'b0;
		end
		run_lvl = 32'(lv);
		run_cnt++;
		ovf_seen |= inc_trunc;
		clear_incoming();
	endfunction

	function automatic void encode_word(input word_t w);
		int unsigned i;
		case (w.mode)
			MODE_BYTE: begin
				i = inc_len;
				if (i < VAL_CAP) begin
					inc_val[i] = w.data;
					if (pfx_eq && i < run_len && run_val[i] == w.data)
						inc_pfx++;
					else
						pfx_eq = 1'b0;
					inc_len = i + 1;
				end else begin
					inc_trunc = 1'b1;
				end
				if (w.last)
					end_value(w.lvl);
			end
			MODE_EMPTY: begin
				clear_incoming();
				end_value(w.lvl);
			end
			MODE_NULL: begin
				clear_incoming();
				if (w.lvl != run_lvl || !run_null || run_cnt == 32'hffffffff)
					close_run();
				run_lvl = 32'(w.lvl);
				run_null = 1'b1;
				run_cnt++;
			end
			default: begin
				clear_incoming();
				close_run();
			end
		endcase
	endfunction

	task automatic push_word(input word_t w);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		mode      <= w.mode;
		data_byte <= w.data;
		level     <= w.lvl;
		last_byte <= w.last;
		do @(posedge clk); while (!in_ready);
		encode_word(w);
		n_sent++;
	endtask

	function automatic word_t mk(input logic [1:0] m, input logic [7:0] d,
		input logic [7:0] l, input logic e);
		word_t w;
		w.mode = m;
		w.data = d;
		w.lvl = l;
		w.last = e;
		return w;
	endfunction

	// sends a whole value, empty ones as an empty word
	task automatic push_value(input logic [7:0] v [$], input logic [7:0] lv);
		if (v.size() == 0) begin
			push_word(mk(MODE_EMPTY, 8'($urandom), lv, 1'($urandom)));
		end else begin
			for (int i = 0; i < v.size(); i++)
				push_word(mk(MODE_BYTE, v[i], (i == v.size() - 1) ? lv : 8'($urandom),
					i == v.size() - 1));
		end
	endtask

	task automatic drain();
		while (record_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (record_q.size() == 0) begin
				$display("%t: unexpected word byte=%h end=%b ovl=%b", $realtime,
					out_byte, record_end, overlong);
				sb_failed = 1'b1;
			end else begin
				if (out_byte !== record_q[0].b || record_end !== record_q[0].rend ||
					overlong !== record_q[0].ovl) begin
					$display("%t: expected byte=%h end=%b ovl=%b, got byte=%h end=%b ovl=%b",
						$realtime, record_q[0].b, record_q[0].rend, record_q[0].ovl,
						out_byte, record_end, overlong);
					sb_failed = 1'b1;
				end
				void'(record_q.pop_front());
			end
		end
	end

	initial begin
		row_t        rows [$];
		row_t        r;
		logic [7:0]  prev [$];
		logic [7:0]  val [$];
		logic [7:0]  lv;
		int          n_before;
		int          n_new;
		int          sent;
		int          pick;
		int          len;
		int          keep;
		int          reps;

		in_valid = 1'b0;
		mode = MODE_FLUSH;
		data_byte = 8'h00;
		level = 8'h00;
		last_byte = 1'b0;
		failed = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		n_pred = 0;
		n_sent = 0;
		run_val = '{default: 8'h00};
		inc_val = '{default: 8'h00};
		run_len = 0;
		run_pfx = 0;
		run_cnt = 0;
		run_lvl = 0;
		run_null = 1'b1;
		ovf_seen = 1'b0;
		clear_incoming();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		r.n_typed = 0;
		r.typed = '{default: 8'h00};
		r.w = mk(MODE_NULL, 8'hff, 8'd5, 1'b1);       rows.insert(rows.size(), r);
		r.w = mk(MODE_FLUSH, 8'hff, 8'hff, 1'b1);     r.n_typed = 3;
		r.typed = '{8'h01, 8'h05, 8'hff, 8'h00, 8'h00, 8'h00}; rows.insert(rows.size(), r);
		r.w = mk(MODE_FLUSH, 8'h00, 8'h00, 1'b0);     r.n_typed = 0; rows.insert(rows.size(), r);
		r.w = mk(MODE_EMPTY, 8'hff, 8'h00, 1'b1);     rows.insert(rows.size(), r);
		r.w = mk(MODE_EMPTY, 8'h00, 8'h00, 1'b0);     rows.insert(rows.size(), r);
		r.w = mk(MODE_FLUSH, 8'h00, 8'h00, 1'b0);     r.n_typed = 3;
		r.typed = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}; rows.insert(rows.size(), r);
		r.n_typed = 0;
		r.w = mk(MODE_BYTE, 8'h61, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h62, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h63, 8'hff, 1'b1);      rows.insert(rows.size(), r);
		r.w = mk(MODE_NULL, 8'h00, 8'hff, 1'b0);      r.n_typed = 6;
		r.typed = '{8'h01, 8'hff, 8'h03, 8'h61, 8'h62, 8'h63}; rows.insert(rows.size(), r);
		r.n_typed = 0;
		// unfinished value dropped by an empty word
		r.w = mk(MODE_BYTE, 8'h00, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_EMPTY, 8'h00, 8'h00, 1'b0);     r.n_typed = 3;
		r.typed = '{8'h01, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}; rows.insert(rows.size(), r);
		r.n_typed = 0;
		// same value, level change only, then a shared prefix
		r.w = mk(MODE_BYTE, 8'h61, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h62, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h63, 8'h01, 1'b1);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h61, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h62, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h63, 8'h02, 1'b1);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h61, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h62, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h63, 8'h00, 1'b0);      rows.insert(rows.size(), r);
		r.w = mk(MODE_BYTE, 8'h64, 8'h02, 1'b1);      rows.insert(rows.size(), r);
		r.w = mk(MODE_FLUSH, 8'h00, 8'h00, 1'b0);     rows.insert(rows.size(), r);

		foreach (rows[k]) begin
			n_before = n_pred;
			push_word(rows[k].w);
			n_new = n_pred - n_before;
			if (rows[k].n_typed != 0) begin
				if (n_new != rows[k].n_typed) begin
					$display("%t: row %0d expected %0d bytes, predicted %0d", $realtime, k,
						rows[k].n_typed, n_new);
					failed = 1'b1;
				end else begin
					for (int j = 0; j < rows[k].n_typed; j++)
						if (record_q[record_q.size() - n_new + j].b !== rows[k].typed[j]) begin
							$display("%t: row %0d byte %0d expected %h, predicted %h",
								$realtime, k, j, rows[k].typed[j],
								record_q[record_q.size() - n_new + j].b);
							failed = 1'b1;
						end
				end
			end
		end
		// hold the sender until every record has drained
		@(negedge clk);
		in_valid <= 1'b0;
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 85; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 85; end
				default: begin idle_pct = 23; stall_pct = 23; end
			endcase
			if (phase == 0) begin
				// long run for a two-byte count
				reps = $urandom_range(128, 132);
				for (int j = 0; j < reps; j++)
					push_word(mk(MODE_EMPTY, 8'($urandom), 8'h07, 1'($urandom)));
			end
			sent = n_sent;
			while (n_sent - sent < 20) begin
				pick = $urandom_range(99);
				if (pick < 65) begin
					// value runs with shared prefixes, sometimes truncated
					len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 7);
					keep = (prev.size() > 0 && $urandom_range(1)) ? $urandom_range(prev.size()) : 0;
					if (keep > len)
						keep = len;
					val.delete();
					for (int j = 0; j < len; j++)
						val.insert(val.size(), (j < keep) ? prev[j] : 8'($urandom));
					lv = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1));
					reps = $urandom_range(1, 3);
					for (int j = 0; j < reps; j++)
						push_value(val, ($urandom_range(4) == 0) ? ~lv : lv);
					prev = val;
				end else if (pick < 78) begin
					push_word(mk(MODE_NULL, 8'($urandom), $urandom_range(2) ?
						8'($urandom_range(1)) : 8'($urandom), 1'($urandom)));
				end else if (pick < 86) begin
					push_word(mk(MODE_FLUSH, 8'($urandom), 8'($urandom), 1'($urandom)));
				end else begin
					push_word(mk(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)));
				end
			end
			push_word(mk(MODE_FLUSH, 8'($urandom), 8'($urandom), 1'($urandom)));
			@(negedge clk);
			in_valid <= 1'b0;
			drain();
		end

		if (!failed && !sb_failed)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
